### hw/rtl/i2c_display_write_master_assert.svh
// Assertion macros for the I2C display write master.
// Included by the RTL files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef I2C_DISPLAY_WRITE_MASTER_ASSERT_SVH
`define I2C_DISPLAY_WRITE_MASTER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define I2CDW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define I2CDW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2CDW_ASSERT(label, prop, msg)
`define I2CDW_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### hw/rtl/i2cdw_pkg.sv
// Shared types, constants and helpers for the I2C display write master.
// No dependencies; used by i2cdw_step and i2c_display_write_master.
`default_nettype none

package i2cdw_pkg;

  localparam logic [7:0]  CTRL_COMMAND      = 8'h00;
  localparam logic [7:0]  CTRL_DATA         = 8'h40;
  localparam logic [7:0]  ADDR_RESET        = 8'h78;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd10;
  localparam logic [2:0]  LAST_BIT          = 3'd7;
  localparam logic [1:0]  LAST_BYTE         = 2'd2;

  localparam int          CFG_ADDR_W        = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_TICKS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ADDRESS     = 3'd4;

  typedef enum logic [10:0] {
    PH_IDLE = 11'b000_0000_0001,
    PH_S1   = 11'b000_0000_0010,
    PH_S2   = 11'b000_0000_0100,
    PH_S3   = 11'b000_0000_1000,
    PH_B1   = 11'b000_0001_0000,
    PH_B2   = 11'b000_0010_0000,
    PH_B3   = 11'b000_0100_0000,
    PH_A1   = 11'b000_1000_0000,
    PH_A2   = 11'b001_0000_0000,
    PH_A3   = 11'b010_0000_0000,
    PH_P1   = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] tick;
    logic [2:0]  bit_cnt;
    logic [1:0]  byte_cnt;
    logic [7:0]  shift;
    logic [7:0]  held_payload;
    logic        held_kind;
    logic        nack;
  } seq_state_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic busy;
    logic done;
    logic nack;
  } result_t;

  // Pin levels {scl, sda} for a phase; the data bit is the shifter's MSB.
  function automatic logic [1:0] pin_levels(phase_t ph, logic msb, logic [2:0] bit_cnt);
    logic [1:0] lv;
    lv = 2'b11;
    unique case (ph)
      PH_S1:   lv = 2'b11;
      PH_S2:   lv = 2'b10;
      PH_S3:   lv = 2'b00;
      PH_B1:   lv = {1'b0, msb};
      PH_B2:   lv = {1'b1, msb};
      PH_B3:   lv = {1'b0, (bit_cnt == LAST_BIT) ? 1'b1 : msb};
      PH_A1:   lv = 2'b01;
      PH_A2:   lv = 2'b11;
      PH_A3:   lv = 2'b01;
      PH_P1:   lv = 2'b10;
      default: lv = 2'b11;
    endcase
    return lv;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/i2c_display_write_master.sv
// Top level of the write-only I2C display master: sequencer state, APB registers, result word.
// Depends on i2cdw_pkg, i2cdw_step and i2c_display_write_master_assert.svh.
//
//   Channel  Handshake                  Carries
//   in_      in_valid / in_ready        request, payload, is_data, sda_sample (one tick)
//   out_     out_valid / out_ready      scl, sda, busy, done, nack (state after the tick)
//   cfg_     psel, penable, pready      phase_ticks at 0x0, address_byte at 0x4
//
// One input word is taken per cycle while in_ready is high; its result word appears in the next cycle.
// The sequencer state and the result register both load at the accepting edge, so a
// result still waiting on out_ready does not block the input while out_ready is high.
// With out_ready low and a result held, in_ready drops until the result is taken.
// Reset (rst_n low, synchronous) idles the bus and restores the register defaults.
`default_nettype none

module i2c_display_write_master (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_request,
  input  logic [7:0]                            in_payload,
  input  logic                                  in_is_data,
  input  logic                                  in_sda_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_scl_level,
  output logic                                  out_sda_level,
  output logic                                  out_busy_res,
  output logic                                  out_done_res,
  output logic                                  out_nack_seen,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [i2cdw_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);
  import i2cdw_pkg::*;

  seq_state_t  seq_r;
  seq_state_t  seq_nxt;
  result_t     res_nxt;
  result_t     res_r;
  logic        out_valid_r;
  logic [15:0] phase_ticks_r;
  logic [7:0]  address_byte_r;
  logic        in_accept;
  logic        cfg_write;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  i2cdw_step u_step (
    .cur          (seq_r),
    .phase_ticks  (phase_ticks_r),
    .address_byte (address_byte_r),
    .request      (in_request),
    .payload      (in_payload),
    .is_data      (in_is_data),
    .sda_sample   (in_sda_sample),
    .nxt          (seq_nxt),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r.phase        <= PH_IDLE;
      seq_r.tick         <= 16'd0;
      seq_r.bit_cnt      <= 3'd0;
      seq_r.byte_cnt     <= 2'd0;
      seq_r.shift        <= 8'd0;
      seq_r.held_payload <= 8'd0;
      seq_r.held_kind    <= 1'b0;
      seq_r.nack         <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      if (in_accept) begin
        seq_r       <= seq_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word; no reset needed since out_valid qualifies it.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_level = res_r.scl;
  assign out_sda_level = res_r.sda;
  assign out_busy_res  = res_r.busy;
  assign out_done_res  = res_r.done;
  assign out_nack_seen = res_r.nack;

  // APB registers. The word offset is taken from bit 2 of the address.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r  <= PHASE_TICKS_RESET;
      address_byte_r <= ADDR_RESET;
    end else if (cfg_write) begin
      if (cfg_paddr[2] == REG_ADDRESS[2]) begin
        address_byte_r <= cfg_pwdata[7:0];
      end else begin
        phase_ticks_r <= cfg_pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_ADDRESS[2]) begin
      cfg_prdata = {24'd0, address_byte_r};
    end else begin
      cfg_prdata = {16'd0, phase_ticks_r};
    end
  end

  `include "i2c_display_write_master_assert.svh"

  `I2CDW_ASSERT(a_done_not_busy, out_valid_r && out_done_res |-> !out_busy_res, "done word still shows busy")
  `I2CDW_ASSERT(a_byte_cnt_range, seq_r.byte_cnt != 2'd3, "byte counter out of range")
  `I2CDW_ASSERT(a_idle_counters, seq_r.phase == PH_IDLE |-> seq_r.bit_cnt == 3'd0 && seq_r.byte_cnt == 2'd0, "idle with counters not cleared")
  `I2CDW_ASSERT(a_start_clears_nack, in_accept && in_request && seq_r.phase == PH_IDLE |=> out_busy_res && !out_nack_seen && out_scl_level && out_sda_level, "start word wrong")

endmodule

`default_nettype wire

### hw/rtl/i2cdw_step.sv
// Next-state and result logic of the bus sequencer for one clock tick.
// Depends on i2cdw_pkg.
`default_nettype none

module i2cdw_step (
  input  i2cdw_pkg::seq_state_t cur,
  input  logic [15:0]           phase_ticks,
  input  logic [7:0]            address_byte,
  input  logic                  request,
  input  logic [7:0]            payload,
  input  logic                  is_data,
  input  logic                  sda_sample,
  output i2cdw_pkg::seq_state_t nxt,
  output i2cdw_pkg::result_t    res
);
  import i2cdw_pkg::*;

  logic [15:0] len;
  logic [16:0] tick_inc;
  logic        phase_end;
  logic        done;
  logic [1:0]  byte_inc;
  logic [1:0]  lv;

  assign len       = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
  assign tick_inc  = {1'b0, cur.tick} + 17'd1;
  assign phase_end = (tick_inc >= {1'b0, len});
  assign byte_inc  = cur.byte_cnt + 2'd1;

  always_comb begin
    nxt  = cur;
    done = 1'b0;
    if (cur.phase == PH_IDLE) begin
      if (request) begin
        nxt.held_payload = payload;
        nxt.held_kind    = is_data;
        nxt.nack         = 1'b0;
        nxt.byte_cnt     = 2'd0;
        nxt.bit_cnt      = 3'd0;
        nxt.shift        = address_byte;
        nxt.phase        = PH_S1;
        nxt.tick         = 16'd0;
      end
    end else if (phase_end) begin
      nxt.tick = 16'd0;
      unique case (cur.phase)
        PH_S1: nxt.phase = PH_S2;
        PH_S2: nxt.phase = PH_S3;
        PH_S3: begin
          nxt.bit_cnt = 3'd0;
          nxt.phase   = PH_B1;
        end
        PH_B1: nxt.phase = PH_B2;
        PH_B2: nxt.phase = PH_B3;
        PH_B3: begin
          nxt.shift = {cur.shift[6:0], 1'b0};
          if (cur.bit_cnt == LAST_BIT) begin
            nxt.bit_cnt = 3'd0;
            nxt.phase   = PH_A1;
          end else begin
            nxt.bit_cnt = cur.bit_cnt + 3'd1;
            nxt.phase   = PH_B1;
          end
        end
        PH_A1: nxt.phase = PH_A2;
        PH_A2: begin
          if (sda_sample) begin
            nxt.nack = 1'b1;
          end
          nxt.phase = PH_A3;
        end
        PH_A3: begin
          if (cur.byte_cnt >= LAST_BYTE) begin
            nxt.phase = PH_P1;
          end else begin
            // Second byte is the control byte, third is the held payload.
            nxt.byte_cnt = byte_inc;
            nxt.shift    = (byte_inc == 2'd1)
                           ? (cur.held_kind ? CTRL_DATA : CTRL_COMMAND)
                           : cur.held_payload;
            nxt.bit_cnt  = 3'd0;
            nxt.phase    = PH_B1;
          end
        end
        PH_P1: begin
          nxt.byte_cnt = 2'd0;
          nxt.phase    = PH_IDLE;
          done         = 1'b1;
        end
        default: nxt.phase = PH_IDLE;
      endcase
    end else begin
      nxt.tick = tick_inc[15:0];
    end
  end

  assign lv       = pin_levels(nxt.phase, nxt.shift[7], nxt.bit_cnt);
  assign res.scl  = lv[1];
  assign res.sda  = lv[0];
  assign res.busy = (nxt.phase != PH_IDLE);
  assign res.done = done;
  assign res.nack = nxt.nack;

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for i2c_display_write_master: random tick words, timed bus checks.
// Depends on i2cdw_pkg and the i2c_display_write_master RTL; needs nothing else.

module tb;
  import i2cdw_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic       request;
    logic [7:0] payload;
    logic       is_data;
    logic       sda_sample;
  } tick_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_request = 1'b0;
  logic [7:0]  in_payload = 8'h00;
  logic        in_is_data = 1'b0;
  logic        in_sda_sample = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_scl_level;
  logic        out_sda_level;
  logic        out_busy_res;
  logic        out_done_res;
  logic        out_nack_seen;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  i2c_display_write_master dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_request    (in_request),
    .in_payload    (in_payload),
    .in_is_data    (in_is_data),
    .in_sda_sample (in_sda_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_scl_level (out_scl_level),
    .out_sda_level (out_sda_level),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_nack_seen (out_nack_seen),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Words waiting to be driven, and bus levels predicted for accepted words.
  tick_word_t tick_words[$];
  result_t    expected_levels[$];

  // Predicted sequencer state and the register copies it runs on.
  logic [15:0] ticks_cfg = PHASE_TICKS_RESET;
  logic [7:0]  addr_cfg = ADDR_RESET;
  phase_t      seq_phase = PH_IDLE;
  int unsigned seq_tick = 0;
  logic [2:0]  seq_bit = '0;
  logic [1:0]  seq_byte = '0;
  logic [7:0]  seq_shift = '0;
  logic [7:0]  seq_payload = '0;
  logic        seq_kind = 1'b0;
  logic        seq_nack = 1'b0;
  logic        seq_scl = 1'b1;
  logic        seq_sda = 1'b1;

  int mismatch_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int transfers_done = 0;
  int transfers_nacked = 0;
  int reg_writes = 0;

  function automatic void load_phase(phase_t ph);
    logic msb;
    msb = seq_shift[7];
    seq_phase = ph;
    seq_tick = 0;
    case (ph)
      PH_S1: begin seq_scl = 1'b1; seq_sda = 1'b1; end
      PH_S2: begin seq_scl = 1'b1; seq_sda = 1'b0; end
      PH_S3: begin seq_scl = 1'b0; seq_sda = 1'b0; end
      PH_B1: begin seq_scl = 1'b0; seq_sda = msb; end
      PH_B2: begin seq_scl = 1'b1; seq_sda = msb; end
      // SDA is let go early on the eighth bit so the slave can drive the acknowledge.
      PH_B3: begin seq_scl = 1'b0; seq_sda = (seq_bit == LAST_BIT) ? 1'b1 : msb; end
      PH_A1: begin seq_scl = 1'b0; seq_sda = 1'b1; end
      PH_A2: begin seq_scl = 1'b1; seq_sda = 1'b1; end
      PH_A3: begin seq_scl = 1'b0; seq_sda = 1'b1; end
      PH_P1: begin seq_scl = 1'b1; seq_sda = 1'b0; end
      default: begin seq_phase = PH_IDLE; seq_scl = 1'b1; seq_sda = 1'b1; end
    endcase
  endfunction

  // Moves to the next pin phase; returns 1 when the stop condition finishes.
  function automatic logic next_phase(logic sda);
    logic fin;
    fin = 1'b0;
    case (seq_phase)
      PH_S1: load_phase(PH_S2);
      PH_S2: load_phase(PH_S3);
      PH_S3: begin
        seq_bit = '0;
        load_phase(PH_B1);
      end
      PH_B1: load_phase(PH_B2);
      PH_B2: load_phase(PH_B3);
      PH_B3: begin
        seq_shift = seq_shift << 1;
        if (seq_bit == LAST_BIT) begin
          seq_bit = '0;
          load_phase(PH_A1);
        end else begin
          seq_bit = seq_bit + 3'd1;
          load_phase(PH_B1);
        end
      end
      PH_A1: load_phase(PH_A2);
      PH_A2: begin
        if (sda) seq_nack = 1'b1;
        load_phase(PH_A3);
      end
      PH_A3: begin
        if (seq_byte >= LAST_BYTE) begin
          load_phase(PH_P1);
        end else begin
          seq_byte = seq_byte + 2'd1;
          if (seq_byte == 2'd1) seq_shift = seq_kind ? CTRL_DATA : CTRL_COMMAND;
          else seq_shift = seq_payload;
          seq_bit = '0;
          load_phase(PH_B1);
        end
      end
      PH_P1: begin
        seq_byte = '0;
        load_phase(PH_IDLE);
        fin = 1'b1;
      end
      default: load_phase(PH_IDLE);
    endcase
    return fin;
  endfunction

  // Advances the predicted sequencer by one tick and returns the bus levels after it.
  function automatic result_t bus_tick(tick_word_t w);
    int unsigned len;
    logic        fin;
    result_t     r;
    len = (ticks_cfg == 16'd0) ? 1 : int'(ticks_cfg);
    fin = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (w.request) begin
        seq_payload = w.payload;
        seq_kind = w.is_data;
        seq_nack = 1'b0;
        seq_byte = '0;
        seq_bit = '0;
        seq_shift = addr_cfg;
        load_phase(PH_S1);
      end
    end else if (seq_tick + 1 >= len) begin
      fin = next_phase(w.sda_sample);
    end else begin
      seq_tick = seq_tick + 1;
    end
    r.scl = seq_scl;
    r.sda = seq_sda;
    r.busy = (seq_phase != PH_IDLE);
    r.done = fin;
    r.nack = seq_nack;
    return r;
  endfunction

  // Sender: bursts of words with random gaps in between.
  tick_word_t cur_word;
  int burst_left = 1;
  int gap_left = 0;
  result_t predicted;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = bus_tick(cur_word);
        expected_levels.push_back(predicted);
        words_sent++;
        if (predicted.done) begin
          transfers_done++;
          if (predicted.nack) transfers_nacked++;
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tick_words.size() > 0) begin
          cur_word = tick_words.pop_front();
          in_request <= cur_word.request;
          in_payload <= cur_word.payload;
          in_is_data <= cur_word.is_data;
          in_sda_sample <= cur_word.sda_sample;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              9:          gap_left = $urandom_range(5, 20);
              default:    gap_left = $urandom_range(1, 4);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: modes of steady acceptance, scattered stalls and longer stall runs.
  int ready_mode = 0;
  int mode_left = 100;
  int stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      mode_left--;
      if (mode_left <= 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (ready_mode == 1) begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end else if (ready_mode == 2 && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(string what, result_t exp_lv, result_t got_lv);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s at word %0d: expected scl=%0b sda=%0b busy=%0b done=%0b nack=%0b, got scl=%0b sda=%0b busy=%0b done=%0b nack=%0b",
               $realtime, what, words_checked, exp_lv.scl, exp_lv.sda, exp_lv.busy,
               exp_lv.done, exp_lv.nack, got_lv.scl, got_lv.sda, got_lv.busy,
               got_lv.done, got_lv.nack);
  endtask

  result_t got_levels;
  result_t want_levels;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_levels = {out_scl_level, out_sda_level, out_busy_res, out_done_res, out_nack_seen};
      if (expected_levels.size() == 0) begin
        report_mismatch("unexpected result word", '0, got_levels);
      end else begin
        want_levels = expected_levels.pop_front();
        if (got_levels.scl !== want_levels.scl || got_levels.sda !== want_levels.sda ||
            got_levels.busy !== want_levels.busy || got_levels.done !== want_levels.done ||
            got_levels.nack !== want_levels.nack)
          report_mismatch("mismatch", want_levels, got_levels);
      end
      words_checked++;
    end
  end

  // Ends the run when neither channel nor the register port has moved for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic void queue_tick(logic req, logic [7:0] pay, logic kind, logic sda);
    tick_word_t w;
    w.request = req;
    w.payload = pay;
    w.is_data = kind;
    w.sda_sample = sda;
    tick_words.push_back(w);
  endfunction

  // Requests arrive on req_pct percent of words; at high rates transfers follow each other back to back.
  function automatic void queue_random_ticks(int n, int req_pct, int nack_pct);
    for (int i = 0; i < n; i++)
      queue_tick($urandom_range(0, 99) < req_pct, 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), $urandom_range(0, 99) < nack_pct);
  endfunction

  task automatic wait_for_drain();
    do @(negedge clk);
    while (tick_words.size() != 0 || in_valid || expected_levels.size() != 0);
  endtask

  task automatic reg_write(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == REG_PHASE_TICKS) ticks_cfg = data[15:0];
    else if (addr == REG_ADDRESS) addr_cfg = data[7:0];
    reg_writes++;
  endtask

  initial begin : stimulus
    int ticks_plan[9];
    int req_plan[3];
    int nack_plan[4];
    ticks_plan = '{1, 2, 0, 3, 1, 5, 2, 1, 4};
    req_plan = '{90, 50, 5};
    nack_plan = '{0, 5, 50, 100};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: idle words, then a data transfer with requests while busy.
    queue_tick(1'b0, 8'hFF, 1'b1, 1'b1);
    queue_tick(1'b0, 8'h00, 1'b0, 1'b0);
    queue_tick(1'b1, 8'hA5, 1'b1, 1'b0);
    for (int i = 0; i < 12; i++)
      queue_tick(1'b1, (i % 2) ? 8'hFF : 8'h00, i[0], i[1]);
    wait_for_drain();

    // A zero phase length mid-transfer cuts the long phase short on the next tick.
    reg_write(REG_PHASE_TICKS, 32'd0);
    reg_write(REG_ADDRESS, 32'hFF);
    for (int i = 0; i < 10; i++)
      queue_tick(1'b0, 8'h5A, 1'b0, 1'b1);
    wait_for_drain();
    reg_write(REG_ADDRESS, 32'h00);

    for (int p = 0; p < 9; p++) begin
      queue_random_ticks(200, req_plan[$urandom_range(0, 2)], nack_plan[$urandom_range(0, 3)]);
      wait_for_drain();
      if (p == 4) begin
        // Longest phase length for a stretch, then back to short phases.
        reg_write(REG_PHASE_TICKS, 32'd65535);
        queue_random_ticks(30, 50, 50);
        wait_for_drain();
      end
      reg_write(REG_PHASE_TICKS, ticks_plan[p]);
      reg_write(REG_ADDRESS, (p == 6) ? 32'hFF : 32'($urandom_range(0, 255)));
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += expected_levels.size();

    $display("Checked %0d of %0d tick words; %0d transfers completed, %0d with a missing ack.",
             words_checked, words_sent, transfers_done, transfers_nacked);
    $display("%0d register writes, phase lengths from 0 to 65535, %0d mismatches.",
             reg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/i2cdw_pkg.sv
hw/rtl/i2cdw_step.sv
hw/rtl/i2c_display_write_master.sv
verif/tb.sv
